FILE: sv/lpeu_pkg.sv
// Shared codes, types and saturation helpers for the Laplacian pseudoinverse edge update.
package lpeu_pkg;

   // request operation codes
   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_READ     = 2'd1;
   localparam logic [1:0] OP_QUERY    = 2'd2;
   localparam logic [1:0] OP_ADD_EDGE = 2'd3;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ERROR = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   // trace change magnitude limit (2^31) and update delta cap (2^34)
   localparam logic [64:0] TRACE_MAX = 65'h0_0000_0000_8000_0000;
   localparam logic [34:0] DELTA_CAP = 35'h4_0000_0000;

   typedef struct packed {
      logic        sat;
      logic [31:0] value;
   } sat_result_type;

   // clamp a 37-bit signed value into signed 32 bits
   function automatic sat_result_type sat32(input logic signed [36:0] x);
      sat_result_type res;
      res.sat = 1'b0;
      res.value = x[31:0];
      if (x > 37'sh0_7FFF_FFFF) begin
         res.sat = 1'b1;
         res.value = 32'h7FFF_FFFF;
      end else if (x < -37'sh0_8000_0000) begin
         res.sat = 1'b1;
         res.value = 32'h8000_0000;
      end
      return res;
   endfunction

   // magnitude of a signed 32-bit value, 2^31 fits unsigned
   function automatic logic [31:0] mag32(input logic [31:0] x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

endpackage

FILE: sv/lpeu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/laplacian_pinv_edge_update.sv
// Laplacian pseudoinverse store with Sherman-Morrison edge query and rank-one update.
//
// Holds an NODE_COUNT x NODE_COUNT Q16.16 matrix in one RAM and takes one request at a
// time; req_ready is low from acceptance until the response has been taken. An entry
// write answers straight from the idle state and an entry read through S_RDW. An edge
// request runs on one shared 32x32 multiplier and one bit-per-cycle restoring divider:
// it fetches the resistance terms (S_ER0..S_ER3), runs two divisions with S_DEN between
// them, builds the difference vector (two reads of the matrix RAM per element), and
// forms the trace product (S_T0..S_T4) before it answers. An add-edge request then
// sweeps every entry row by row; the sweep is paced by the multiplier passes of each
// entry: v_r v_k, then w times its low and high parts. Matrix entries must be written
// before they are read; the store is not cleared.
module laplacian_pinv_edge_update
   import lpeu_pkg::*;
#(
   parameter int NODE_COUNT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [5:0]         req_node_a,
   input  logic [5:0]         req_node_b,
   input  logic signed [31:0] req_data_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_data_out,
   output logic [1:0]         rsp_status
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int AW = $clog2(NODE_COUNT * NODE_COUNT);
   localparam logic [IW-1:0] LAST_INDEX = IW'(NODE_COUNT - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_RDW,
      S_ER0, S_ER1, S_ER2, S_ER3, S_DIV1, S_DEN, S_DIV2,
      S_VRA, S_VRB, S_VSUB, S_VMUL, S_VACC,
      S_T0, S_T1, S_T2, S_T3, S_T4,
      S_UROW, S_UROWW, S_UVK, S_UM1, S_UM2, S_UM3, S_UM4, S_UM5, S_UM6, S_UWR
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]         op_ff, op_in;
   logic [IW-1:0]      a_ff, a_in, b_ff, b_in, k_ff, k_in, r_ff, r_in;
   logic signed [34:0] rsum_ff, rsum_in;
   logic [35:0]        divisor_ff, divisor_in, div_rem_ff, div_rem_in;
   logic [32:0]        div_quo_ff, div_quo_in, w_ff, w_in;
   logic [5:0]         div_cnt_ff, div_cnt_in;
   logic [31:0]        x_ff, x_in, vr_ff, vr_in, l_ff, l_in;
   logic [63:0]        sum_ff, sum_in, prod_ff;
   logic [31:0]        mul_x_ff, mul_x_in, mul_y_ff, mul_y_in;
   logic [80:0]        acc_ff, acc_in;
   logic [47:0]        m16_ff, m16_in;
   logic               neg_ff, neg_in, sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic [AW-1:0] pinv_rd_addr, pinv_wr_addr;
   logic [31:0]   pinv_rd_data, pinv_wr_data;
   logic          pinv_we;
   logic [IW-1:0] vec_rd_addr, vec_wr_addr;
   logic [31:0]   vec_rd_data, vec_wr_data;
   logic          vec_we;

   logic               accept, in_range;
   logic [36:0]        div_shift;
   logic               div_ge;
   logic [35:0]        div_rem_next;
   logic signed [36:0] denom;
   logic signed [36:0] vdiff, nv;
   sat_result_type     vsat, usat;
   logic [64:0]        sum_add, p16;
   logic [34:0]        delta;
   logic [31:0]        trace_mag;

   function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] row,
                                               input logic [IW-1:0] col);
      return AW'(row * NODE_COUNT + col);
   endfunction

   lpeu_ram #(.WIDTH(32), .DEPTH(NODE_COUNT * NODE_COUNT)) u_pinv_ram (
      .clock   (clock),
      .wr_en   (pinv_we),
      .wr_addr (pinv_wr_addr),
      .wr_data (pinv_wr_data),
      .rd_addr (pinv_rd_addr),
      .rd_data (pinv_rd_data)
   );

   lpeu_ram #(.WIDTH(32), .DEPTH(NODE_COUNT)) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (vec_wr_addr),
      .wr_data (vec_wr_data),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_rd_data)
   );

   // handshake
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign in_range  = ({26'd0, req_node_a} < 32'(NODE_COUNT)) &&
                      ({26'd0, req_node_b} < 32'(NODE_COUNT));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = $signed(rsp_data_ff);
   assign rsp_status   = rsp_status_ff;

   // datapath helpers
   always_comb begin
      div_shift    = {div_rem_ff, (div_cnt_ff == 6'd32)};
      div_ge       = div_shift >= {1'b0, divisor_ff};
      div_rem_next = div_ge ? 36'(div_shift - {1'b0, divisor_ff}) : div_shift[35:0];
      denom        = $signed({4'd0, div_quo_ff}) + $signed({{2{rsum_ff[34]}}, rsum_ff});
      vdiff        = $signed({{5{x_ff[31]}}, x_ff}) -
                     $signed({{5{pinv_rd_data[31]}}, pinv_rd_data});
      vsat         = sat32(vdiff);
      sum_add      = {1'b0, sum_ff} + {1'b0, prod_ff};
      p16          = acc_ff[80:16];
      trace_mag    = (p16 > TRACE_MAX) ? 32'h8000_0000 : acc_ff[47:16];
      delta        = (p16 >= 65'(DELTA_CAP)) ? DELTA_CAP : acc_ff[50:16];
      if (neg_ff) begin
         nv = $signed({{5{l_ff[31]}}, l_ff}) + $signed({2'b00, delta});
      end else begin
         nv = $signed({{5{l_ff[31]}}, l_ff}) - $signed({2'b00, delta});
      end
      usat = sat32(nv);
   end

   // sequencer next state and datapath register updates
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      rsum_in       = rsum_ff;
      divisor_in    = divisor_ff;
      div_rem_in    = div_rem_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      w_in          = w_ff;
      x_in          = x_ff;
      vr_in         = vr_ff;
      l_in          = l_ff;
      sum_in        = sum_ff;
      mul_x_in      = mul_x_ff;
      mul_y_in      = mul_y_ff;
      acc_in        = acc_ff;
      m16_in        = m16_ff;
      neg_in        = neg_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      pinv_rd_addr  = cell_addr(a_ff, b_ff);
      pinv_we       = 1'b0;
      pinv_wr_addr  = cell_addr(a_ff, b_ff);
      pinv_wr_data  = usat.value;
      vec_rd_addr   = k_ff;
      vec_we        = 1'b0;
      vec_wr_addr   = k_ff;
      vec_wr_data   = vsat.value;

      unique case (state_ff)
         S_IDLE: begin
            pinv_rd_addr = cell_addr(IW'(req_node_a), IW'(req_node_b));
            if (accept) begin
               op_in      = req_operation;
               a_in       = IW'(req_node_a);
               b_in       = IW'(req_node_b);
               divisor_in = {5'd0, req_data_in[30:0]};
               sat_in     = 1'b0;
               if (!in_range) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = 32'd0;
                  rsp_status_in = ST_ERROR;
               end else if (req_operation == OP_WRITE) begin
                  pinv_we       = 1'b1;
                  pinv_wr_addr  = cell_addr(IW'(req_node_a), IW'(req_node_b));
                  pinv_wr_data  = req_data_in;
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = 32'd0;
                  rsp_status_in = ST_OK;
               end else if (req_operation == OP_READ) begin
                  state_in = S_RDW;
               end else if (req_data_in <= 32'sd0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = 32'd0;
                  rsp_status_in = ST_ERROR;
               end else begin
                  state_in = S_ER0;
               end
            end
         end
         S_RDW: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = pinv_rd_data;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end
         // resistance R = L[a][a] + L[b][b] - 2 L[a][b]
         S_ER0: begin
            pinv_rd_addr = cell_addr(a_ff, a_ff);
            state_in     = S_ER1;
         end
         S_ER1: begin
            pinv_rd_addr = cell_addr(b_ff, b_ff);
            rsum_in      = 35'($signed(pinv_rd_data));
            state_in     = S_ER2;
         end
         S_ER2: begin
            pinv_rd_addr = cell_addr(a_ff, b_ff);
            rsum_in      = rsum_ff + 35'($signed(pinv_rd_data));
            state_in     = S_ER3;
         end
         S_ER3: begin
            rsum_in    = rsum_ff - (35'($signed(pinv_rd_data)) <<< 1);
            div_rem_in = 36'd0;
            div_quo_in = 33'd0;
            div_cnt_in = 6'd32;
            state_in   = S_DIV1;
         end
         // 1/c, one quotient bit a cycle
         S_DIV1: begin
            div_rem_in = div_rem_next;
            div_quo_in = {div_quo_ff[31:0], div_ge};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd0) begin
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (denom <= 37'sd0) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = 32'd0;
               rsp_status_in = ST_ERROR;
               state_in      = S_IDLE;
            end else begin
               divisor_in = denom[35:0];
               div_rem_in = 36'd0;
               div_quo_in = 33'd0;
               div_cnt_in = 6'd32;
               state_in   = S_DIV2;
            end
         end
         // w = 1 / denom
         S_DIV2: begin
            div_rem_in = div_rem_next;
            div_quo_in = {div_quo_ff[31:0], div_ge};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd0) begin
               w_in     = {div_quo_ff[31:0], div_ge};
               k_in     = '0;
               sum_in   = 64'd0;
               state_in = S_VRA;
            end
         end
         // difference vector and its squared norm
         S_VRA: begin
            pinv_rd_addr = cell_addr(k_ff, a_ff);
            state_in     = S_VRB;
         end
         S_VRB: begin
            pinv_rd_addr = cell_addr(k_ff, b_ff);
            x_in         = pinv_rd_data;
            state_in     = S_VSUB;
         end
         S_VSUB: begin
            vec_we   = 1'b1;
            sat_in   = sat_ff | vsat.sat;
            mul_x_in = mag32(vsat.value);
            mul_y_in = mag32(vsat.value);
            state_in = S_VMUL;
         end
         S_VMUL: begin
            state_in = S_VACC;
         end
         S_VACC: begin
            if (sum_add[64]) begin
               sum_in = '1;
               sat_in = 1'b1;
            end else begin
               sum_in = sum_add[63:0];
            end
            if (k_ff == LAST_INDEX) begin
               state_in = S_T0;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = S_VRA;
            end
         end
         // trace change w * (|v|^2 >> 16), in two partial products
         S_T0: begin
            mul_x_in = w_ff[31:0];
            mul_y_in = sum_ff[47:16];
            state_in = S_T1;
         end
         S_T1: begin
            mul_x_in = w_ff[31:0];
            mul_y_in = {16'd0, sum_ff[63:48]};
            state_in = S_T2;
         end
         S_T2: begin
            acc_in   = 81'(prod_ff);
            state_in = S_T3;
         end
         S_T3: begin
            acc_in = acc_ff + (81'(prod_ff) << 32) +
                     (w_ff[32] ? (81'(sum_ff[63:16]) << 32) : 81'd0);
            state_in = S_T4;
         end
         S_T4: begin
            rsp_data_in = 32'd0 - trace_mag;
            if (p16 > TRACE_MAX) begin
               sat_in = 1'b1;
            end
            if (op_ff == OP_QUERY) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (sat_ff || (p16 > TRACE_MAX)) ? ST_SAT : ST_OK;
               state_in      = S_IDLE;
            end else begin
               r_in     = '0;
               state_in = S_UROW;
            end
         end
         // rank-one update L -= w v v^T, row by row
         S_UROW: begin
            vec_rd_addr = r_ff;
            k_in        = '0;
            state_in    = S_UROWW;
         end
         S_UROWW: begin
            vr_in    = vec_rd_data;
            state_in = S_UVK;
         end
         S_UVK: begin
            pinv_rd_addr = cell_addr(r_ff, k_ff);
            vec_rd_addr  = k_ff;
            state_in     = S_UM1;
         end
         S_UM1: begin
            l_in     = pinv_rd_data;
            neg_in   = vr_ff[31] ^ vec_rd_data[31];
            mul_x_in = mag32(vr_ff);
            mul_y_in = mag32(vec_rd_data);
            state_in = S_UM2;
         end
         S_UM2: begin
            state_in = S_UM3;
         end
         S_UM3: begin
            m16_in   = prod_ff[63:16];
            mul_x_in = w_ff[31:0];
            mul_y_in = prod_ff[47:16];
            state_in = S_UM4;
         end
         S_UM4: begin
            mul_x_in = w_ff[31:0];
            mul_y_in = {16'd0, m16_ff[47:32]};
            state_in = S_UM5;
         end
         S_UM5: begin
            acc_in   = 81'(prod_ff);
            state_in = S_UM6;
         end
         S_UM6: begin
            acc_in = acc_ff + (81'(prod_ff) << 32) +
                     (w_ff[32] ? (81'(m16_ff) << 32) : 81'd0);
            state_in = S_UWR;
         end
         S_UWR: begin
            pinv_we      = 1'b1;
            pinv_wr_addr = cell_addr(r_ff, k_ff);
            sat_in       = sat_ff | usat.sat;
            if (k_ff != LAST_INDEX) begin
               k_in     = k_ff + IW'(1);
               state_in = S_UVK;
            end else if (r_ff != LAST_INDEX) begin
               r_in     = r_ff + IW'(1);
               state_in = S_UROW;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (sat_ff || usat.sat) ? ST_SAT : ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      state_ff      <= state_in;
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      k_ff          <= k_in;
      r_ff          <= r_in;
      rsum_ff       <= rsum_in;
      divisor_ff    <= divisor_in;
      div_rem_ff    <= div_rem_in;
      div_quo_ff    <= div_quo_in;
      div_cnt_ff    <= div_cnt_in;
      w_ff          <= w_in;
      x_ff          <= x_in;
      vr_ff         <= vr_in;
      l_ff          <= l_in;
      sum_ff        <= sum_in;
      mul_x_ff      <= mul_x_in;
      mul_y_ff      <= mul_y_in;
      prod_ff       <= mul_x_ff * mul_y_ff;
      acc_ff        <= acc_in;
      m16_ff        <= m16_in;
      neg_ff        <= neg_in;
      sat_ff        <= sat_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end
   end

   // no new request while a response is pending
   a_ready_vs_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while response pending");

   // entry read response follows acceptance by way of the S_RDW state
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && in_range && req_operation == OP_READ) |-> ##2 rsp_valid)
      else $error("entry read response late");

   // error responses carry zero data
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ERROR) |-> rsp_data_out == 32'sd0)
      else $error("error response with nonzero data");

   // matrix writes never overlap a pending response
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      pinv_we |-> !rsp_valid_ff)
      else $error("matrix write while response pending");

endmodule

FILE: tb/sv/lpeu_checker.sv
// Response checker: predicts each response of the pseudoinverse block and compares it.
module lpeu_checker
   import lpeu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [5:0]         req_node_a,
   input  logic [5:0]         req_node_b,
   input  logic signed [31:0] req_data_in,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_data_out,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [31:0] data;
      logic [1:0]  status;
   } response_type;

   localparam int N = 64;
   localparam logic [127:0] DELTA_LIMIT = 128'd1 << 34;
   localparam logic [127:0] TRACE_LIMIT = 128'd1 << 31;
   localparam logic [127:0] SUM_LIMIT   = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};

   // shadow copy of the matrix and the difference vector
   logic signed [31:0] pinv_mem [N][N];
   logic signed [31:0] diff_vec [N];
   response_type       expected_q [$];

   function automatic logic [127:0] magnitude(input longint x);
      return x < 0 ? 128'(-x) : 128'(x);
   endfunction

   // clamp to signed 32 bits, flagging saturation
   function automatic longint clamp_word(input longint x, inout bit sat);
      if (x > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   task automatic predict_response(input logic [1:0] op, input logic [5:0] a,
                                   input logic [5:0] b, input logic signed [31:0] d,
                                   output response_type res);
      bit           sat;
      longint       rsum, inv_c, denom, vk, vr, nv;
      logic [127:0] w, sum, norm16, tt, m16, delta;
      sat = 1'b0;
      res.data = '0;
      res.status = ST_OK;
      if (op == OP_WRITE) begin
         pinv_mem[a][b] = d;
         return;
      end
      if (op == OP_READ) begin
         res.data = pinv_mem[a][b];
         return;
      end
      // edge query / add edge
      if (d <= 0) begin
         res.status = ST_ERROR;
         return;
      end
      rsum = longint'(pinv_mem[a][a]) + longint'(pinv_mem[b][b])
           - 2 * longint'(pinv_mem[a][b]);
      inv_c = (64'sd1 <<< 32) / longint'(d);
      denom = inv_c + rsum;
      if (denom <= 0) begin
         res.status = ST_ERROR;
         return;
      end
      w = 128'((64'sd1 <<< 32) / denom);
      sum = '0;
      for (int k = 0; k < N; k++) begin
         vk = clamp_word(longint'(pinv_mem[k][a]) - longint'(pinv_mem[k][b]), sat);
         diff_vec[k] = vk[31:0];
         sum += magnitude(vk) * magnitude(vk);
      end
      if (sum > SUM_LIMIT) begin
         sum = SUM_LIMIT;
         sat = 1'b1;
      end
      norm16 = sum >> 16;
      tt = (w * norm16) >> 16;
      if (tt > TRACE_LIMIT) begin
         tt = TRACE_LIMIT;
         sat = 1'b1;
      end
      res.data = 32'd0 - tt[31:0];
      // rank-one update from the pre-update difference vector
      if (op == OP_ADD_EDGE) begin
         for (int r = 0; r < N; r++) begin
            vr = longint'(diff_vec[r]);
            for (int k = 0; k < N; k++) begin
               vk = longint'(diff_vec[k]);
               m16 = (magnitude(vr) * magnitude(vk)) >> 16;
               delta = (w * m16) >> 16;
               if (delta > DELTA_LIMIT) delta = DELTA_LIMIT;
               if ((vr < 0) != (vk < 0)) nv = longint'(pinv_mem[r][k]) + longint'(delta);
               else nv = longint'(pinv_mem[r][k]) - longint'(delta);
               pinv_mem[r][k] = 32'(clamp_word(nv, sat));
            end
         end
      end
      res.status = sat ? ST_SAT : ST_OK;
   endtask

   // predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      response_type res, exp_res;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_response(req_operation, req_node_a, req_node_b, req_data_in, res);
            expected_q.insert(expected_q.size(), res);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response data %h status %0d", $time,
                        rsp_data_out, rsp_status);
               fail_count++;
            end else begin
               exp_res = expected_q.pop_front();
               if (rsp_data_out !== exp_res.data) begin
                  $display("%0t: data_out expected %h actual %h", $time,
                           exp_res.data, rsp_data_out);
                  fail_count++;
               end
               if (rsp_status !== exp_res.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_res.status, rsp_status);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: tb/sv/tb_laplacian_pinv_edge_update.sv
// Testbench top: drives requests and response stalls, and reports the verdict.
module tb_laplacian_pinv_edge_update
   import lpeu_pkg::*;
();

   localparam int N = 64;
   localparam int STALL_LIMIT = 150000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_operation = OP_WRITE;
   logic [5:0]         req_node_a = '0;
   logic [5:0]         req_node_b = '0;
   logic signed [31:0] req_data_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_data_out;
   logic [1:0]         rsp_status;
   int                 fail_count;
   int                 pending;
   bit                 idle_on = 1'b0;
   int                 quiet_cycles = 0;

   always #5 clock = ~clock;

   laplacian_pinv_edge_update u_dut (.*);

   lpeu_checker u_checker (.*);

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // response stalls in random bursts
   initial begin
      @(posedge clock iff !reset);
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // issue one request, hold until accepted
   task automatic send_request(input logic [1:0] op, input int a, input int b,
                               input logic [31:0] d);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_node_a    <= 6'(a);
      req_node_b    <= 6'(b);
      req_data_in   <= d;
      do @(posedge clock); while (!req_ready);
   endtask

   // mostly small Q16.16 entries, sometimes any 32-bit value
   function automatic logic [31:0] entry_value();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return 32'(int'($urandom_range(0, 262144)) - 131072);
   endfunction

   // mostly moderate conductances, sometimes any 32-bit value
   function automatic logic [31:0] conductance();
      if ($urandom_range(0, 5) == 0) return $urandom;
      return $urandom_range(16384, 524288);
   endfunction

   initial begin
      int sel, edge_adds;
      edge_adds = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load every entry: larger diagonal, small off-diagonal
      for (int r = 0; r < N; r++)
         for (int k = 0; k < N; k++)
            send_request(OP_WRITE, r, k, (r == k) ? $urandom_range(65536, 262144)
                                                  : 32'(int'($urandom_range(0, 65536)) - 32768));

      // directed: field extremes, error paths, saturation, equal endpoints
      idle_on = 1'b1;
      send_request(OP_WRITE, 0, 1, 32'h7FFF_FFFF);
      send_request(OP_WRITE, 1, 0, 32'h8000_0000);
      send_request(OP_READ, 0, 1, '0);
      send_request(OP_READ, 1, 0, 32'hFFFF_FFFF);
      send_request(OP_READ, 63, 63, '0);
      send_request(OP_QUERY, 4, 5, 32'd0);
      send_request(OP_QUERY, 4, 5, 32'h8000_0000);
      send_request(OP_ADD_EDGE, 4, 5, 32'hFFFF_0000);
      send_request(OP_QUERY, 4, 5, 32'h7FFF_FFFF);
      send_request(OP_QUERY, 4, 5, 32'd1);
      send_request(OP_QUERY, 7, 7, 32'h0001_0000);
      send_request(OP_ADD_EDGE, 9, 9, 32'h0001_0000);
      // resistance far below -1/c gives a non-positive denominator
      send_request(OP_WRITE, 2, 2, '0);
      send_request(OP_WRITE, 3, 3, '0);
      send_request(OP_WRITE, 2, 3, 32'h4000_0000);
      send_request(OP_QUERY, 2, 3, 32'h0001_0000);
      send_request(OP_ADD_EDGE, 2, 3, 32'h0001_0000);
      send_request(OP_WRITE, 2, 3, '0);
      send_request(OP_QUERY, 0, 1, 32'h0001_0000);
      send_request(OP_ADD_EDGE, 0, 1, 32'h0001_0000);
      send_request(OP_ADD_EDGE, 10, 20, 32'h0002_0000);
      send_request(OP_READ, 10, 20, '0);
      send_request(OP_READ, 0, 0, '0);
      edge_adds = 5;

      // random mix of writes, reads, queries and edge additions
      for (int i = 0; i < 115; i++) begin
         if (i == 40) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         idle_on = !(i >= 50 && i < 65) && i < 85;
         sel = $urandom_range(0, 99);
         if (sel < 35)
            send_request(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), entry_value());
         else if (sel < 65)
            send_request(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         else if (sel < 90 || edge_adds >= 14)
            send_request(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), conductance());
         else begin
            send_request(OP_ADD_EDGE, $urandom_range(0, 63), $urandom_range(0, 63),
                         conductance());
            edge_adds++;
         end
      end
      req_valid <= 1'b0;

      // drain outstanding responses, then settle
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: laplacian_pinv_edge_update.f
sv/lpeu_pkg.sv
sv/lpeu_ram.sv
sv/laplacian_pinv_edge_update.sv
tb/sv/lpeu_checker.sv
tb/sv/tb_laplacian_pinv_edge_update.sv
